FILE: rtl/rpal_pkg.sv
// ----------------------------------------------------------------------------
// rpal_pkg: shared widths and constants for the point-about-line rotator
// Fixed-point formats, field widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rpal_pkg;

	localparam int COORD_W       = 32;  // Q.F coordinate
	localparam int ANGLE_W       = 16;  // binary angle
	localparam int DIFF_W        = 33;  // exact difference of two coordinates
	localparam int AX_W          = 27;  // axis component, Q.24, +/-2 units
	localparam int SQ_W          = 28;  // axis product, Q.24
	localparam int SUM_W         = 29;  // sum of two axis products
	localparam int TRIG_W        = 34;  // CORDIC x/y/z datapath, x/y in Q4.30
	localparam int MAT_W         = 30;  // matrix entry, Q.24
	localparam int WIDE_W        = 64;  // product and accumulator width
	localparam int ROW_W         = 40;  // accumulator after the Q.24 shift
	localparam int RES_W         = 41;  // row plus start coordinate
	localparam int MAT_FRAC      = 24;
	localparam int TRIG_FRAC     = 30;
	localparam int ATAN_COUNT    = 24;
	localparam int CORDIC_X0     = 652032874;

	localparam int DEF_COORD_FRAC_BITS = 16;
	localparam int DEF_TRIG_STAGES     = 16;

	localparam int IN_DATA_W  = 9 * COORD_W + ANGLE_W;
	localparam int OUT_DATA_W = 3 * COORD_W;

	typedef struct packed {
		logic signed [DIFF_W-1:0]  vx;
		logic signed [DIFF_W-1:0]  vy;
		logic signed [DIFF_W-1:0]  vz;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sz;
	} side_t;

	typedef struct packed {
		logic signed [AX_W-1:0] a;
		logic signed [AX_W-1:0] b;
		logic signed [AX_W-1:0] c;
	} axis_t;

	// arctangent of 2^-i as a 32-bit turn fraction
	function automatic logic signed [TRIG_W-1:0] atan_turn(input int unsigned idx);
		logic [31:0] t;
		case (idx)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return signed'({2'b00, t});
	endfunction

endpackage

FILE: rtl/rotate_point_about_line_core.sv
// ----------------------------------------------------------------------------
// rotate_point_about_line_core: rotate a 3-D point about an arbitrary axis
// Returns R(P - S) + S for the axis direction E - S and a binary angle.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload (tdata, lowest bits first)
// s_axis    in   point_x/y/z, line_start_x/y/z, line_end_x/y/z, turn_angle
// m_axis    out  rotated_x, rotated_y, rotated_z
//
// One transfer enters per cycle while the pipeline is not held; it passes one input
// stage, one CORDIC stage per iteration, then five matrix/output stages.
// The whole pipeline advances on one enable: it holds when the output
// register is full and m_axis_tready is low, otherwise every stage moves.
// Reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rotate_point_about_line_core #(
	parameter int COORD_FRAC_BITS = rpal_pkg::DEF_COORD_FRAC_BITS,
	parameter int TRIG_STAGES     = rpal_pkg::DEF_TRIG_STAGES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// point_x, point_y, point_z, line_start_x, line_start_y, line_start_z,
	// line_end_x, line_end_y, line_end_z, turn_angle
	input  logic [rpal_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// rotated_x, rotated_y, rotated_z
	output logic [rpal_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	localparam int CW = rpal_pkg::COORD_W;
	localparam int DW = rpal_pkg::DIFF_W;
	localparam int TW = rpal_pkg::TRIG_W;
	localparam int WW = rpal_pkg::WIDE_W;
	localparam int MW = rpal_pkg::MAT_W;
	// CORDIC iterations, capped at the table length
	localparam int NC = (TRIG_STAGES < rpal_pkg::ATAN_COUNT) ? TRIG_STAGES
		: rpal_pkg::ATAN_COUNT;
	localparam logic signed [DW-1:0] AX_LIM = DW'(64'sd1 <<< (COORD_FRAC_BITS + 1));
	localparam int AX_SH = rpal_pkg::MAT_FRAC - COORD_FRAC_BITS;
	localparam logic signed [TW-1:0] TRIG_ONE = TW'(64'sd1 <<< rpal_pkg::TRIG_FRAC);
	localparam logic signed [WW-1:0] ROUND_HALF = WW'(64'sd1 <<< (rpal_pkg::MAT_FRAC - 1));

	// global advance: move when the output slot is empty or being drained
	logic en;
	logic out_valid_s6;
	assign en = ~out_valid_s6 | m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: unpack, differences, axis, angle fold --------
	logic signed [CW-1:0] px, py, pz, sx, sy, sz, ex, ey, ez;
	logic [rpal_pkg::ANGLE_W-1:0] ang;
	assign px  = s_axis_tdata[0*CW +: CW];
	assign py  = s_axis_tdata[1*CW +: CW];
	assign pz  = s_axis_tdata[2*CW +: CW];
	assign sx  = s_axis_tdata[3*CW +: CW];
	assign sy  = s_axis_tdata[4*CW +: CW];
	assign sz  = s_axis_tdata[5*CW +: CW];
	assign ex  = s_axis_tdata[6*CW +: CW];
	assign ey  = s_axis_tdata[7*CW +: CW];
	assign ez  = s_axis_tdata[8*CW +: CW];
	assign ang = s_axis_tdata[9*CW +: rpal_pkg::ANGLE_W];

	function automatic logic signed [rpal_pkg::AX_W-1:0] axis_comp(
		input logic signed [CW-1:0] e, input logic signed [CW-1:0] s);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] dc;
		logic signed [DW-1:0] dsh;
		d = DW'(e) - DW'(s);
		if (d < -AX_LIM)
			dc = -AX_LIM;
		else if (d > AX_LIM)
			dc = AX_LIM;
		else
			dc = d;
		dsh = dc <<< AX_SH;
		return dsh[rpal_pkg::AX_W-1:0];
	endfunction

	rpal_pkg::side_t side_in;
	rpal_pkg::axis_t axis_in;
	logic            flip_in;
	logic [31:0]     th_in;
	always_comb begin
		side_in.vx = DW'(px) - DW'(sx);
		side_in.vy = DW'(py) - DW'(sy);
		side_in.vz = DW'(pz) - DW'(sz);
		side_in.sx = sx;
		side_in.sy = sy;
		side_in.sz = sz;
		axis_in.a  = axis_comp(ex, sx);
		axis_in.b  = axis_comp(ey, sy);
		axis_in.c  = axis_comp(ez, sz);
		// quadrants 1 and 2: take half a turn off, negate sin and cos later
		flip_in    = ang[15] ^ ang[14];
		th_in      = {ang[15] ^ flip_in, ang[14:0], 16'h0000};
	end

	// CORDIC chain: index 0 is the input stage, k holds k iterations done
	logic                   vld_sk  [0:NC];
	logic                   flip_sk [0:NC];
	rpal_pkg::side_t        side_sk [0:NC];
	rpal_pkg::axis_t        axis_sk [0:NC];
	logic signed [TW-1:0]   cx_sk   [0:NC];
	logic signed [TW-1:0]   cy_sk   [0:NC];
	logic signed [TW-1:0]   cz_sk   [0:NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else if (en) begin
			vld_sk[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_sk[0] <= flip_in;
			side_sk[0] <= side_in;
			axis_sk[0] <= axis_in;
			cx_sk[0]   <= TW'(rpal_pkg::CORDIC_X0);
			cy_sk[0]   <= '0;
			cz_sk[0]   <= TW'(signed'(th_in));
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < NC; i++) begin : g_cordic
		localparam logic signed [TW-1:0] ATAN_I = rpal_pkg::atan_turn(i);
		logic signed [TW-1:0] xs, ys;
		assign xs = cx_sk[i] >>> i;
		assign ys = cy_sk[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[i+1] <= 1'b0;
			end else if (en) begin
				vld_sk[i+1] <= vld_sk[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_sk[i+1] <= flip_sk[i];
				side_sk[i+1] <= side_sk[i];
				axis_sk[i+1] <= axis_sk[i];
				if (!cz_sk[i][TW-1]) begin
					cx_sk[i+1] <= cx_sk[i] - ys;
					cy_sk[i+1] <= cy_sk[i] + xs;
					cz_sk[i+1] <= cz_sk[i] - ATAN_I;
				end else begin
					cx_sk[i+1] <= cx_sk[i] + ys;
					cy_sk[i+1] <= cy_sk[i] - xs;
					cz_sk[i+1] <= cz_sk[i] + ATAN_I;
				end
			end
		end
	end

	// ---------------- stage 2: axis products, unfold sin/cos ---------------
	logic                               vld_s2;
	rpal_pkg::side_t                    side_s2;
	rpal_pkg::axis_t                    axis_s2;
	logic signed [rpal_pkg::SQ_W-1:0]   aa_s2, ab_s2, ac_s2, bb_s2, bc_s2, cc_s2;
	logic signed [TW-1:0]               cs_s2, sn_s2, oc_s2;

	function automatic logic signed [rpal_pkg::SQ_W-1:0] mul_mat(
		input logic signed [rpal_pkg::AX_W-1:0] u,
		input logic signed [rpal_pkg::AX_W-1:0] v);
		logic signed [WW-1:0] uw, vw, p;
		uw = WW'(u);
		vw = WW'(v);
		p  = uw * vw;
		return p[rpal_pkg::MAT_FRAC +: rpal_pkg::SQ_W];
	endfunction

	logic signed [TW-1:0] cs_n;
	assign cs_n = flip_sk[NC] ? -cx_sk[NC] : cx_sk[NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_sk[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_sk[NC];
			axis_s2 <= axis_sk[NC];
			aa_s2   <= mul_mat(axis_sk[NC].a, axis_sk[NC].a);
			ab_s2   <= mul_mat(axis_sk[NC].a, axis_sk[NC].b);
			ac_s2   <= mul_mat(axis_sk[NC].a, axis_sk[NC].c);
			bb_s2   <= mul_mat(axis_sk[NC].b, axis_sk[NC].b);
			bc_s2   <= mul_mat(axis_sk[NC].b, axis_sk[NC].c);
			cc_s2   <= mul_mat(axis_sk[NC].c, axis_sk[NC].c);
			cs_s2   <= cs_n;
			sn_s2   <= flip_sk[NC] ? -cy_sk[NC] : cy_sk[NC];
			oc_s2   <= TRIG_ONE - cs_n;
		end
	end

	// ---------------- stage 3: trig-weighted terms -------------------------
	function automatic logic signed [MW-1:0] mul_trig(
		input logic signed [rpal_pkg::SUM_W-1:0] u,
		input logic signed [TW-1:0] t);
		logic signed [WW-1:0] uw, tw, p;
		uw = WW'(u);
		tw = WW'(t);
		p  = uw * tw;
		return p[rpal_pkg::TRIG_FRAC +: MW];
	endfunction

	logic                             vld_s3;
	rpal_pkg::side_t                  side_s3;
	logic signed [rpal_pkg::SQ_W-1:0] aa_s3, bb_s3, cc_s3;
	logic signed [MW-1:0]             d0_s3, d1_s3, d2_s3;
	logic signed [MW-1:0]             ab_oc_s3, ac_oc_s3, bc_oc_s3;
	logic signed [MW-1:0]             a_sn_s3, b_sn_s3, c_sn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side_s2;
			aa_s3    <= aa_s2;
			bb_s3    <= bb_s2;
			cc_s3    <= cc_s2;
			d0_s3    <= mul_trig(rpal_pkg::SUM_W'(bb_s2) + rpal_pkg::SUM_W'(cc_s2), cs_s2);
			d1_s3    <= mul_trig(rpal_pkg::SUM_W'(aa_s2) + rpal_pkg::SUM_W'(cc_s2), cs_s2);
			d2_s3    <= mul_trig(rpal_pkg::SUM_W'(aa_s2) + rpal_pkg::SUM_W'(bb_s2), cs_s2);
			ab_oc_s3 <= mul_trig(rpal_pkg::SUM_W'(ab_s2), oc_s2);
			ac_oc_s3 <= mul_trig(rpal_pkg::SUM_W'(ac_s2), oc_s2);
			bc_oc_s3 <= mul_trig(rpal_pkg::SUM_W'(bc_s2), oc_s2);
			a_sn_s3  <= mul_trig(rpal_pkg::SUM_W'(axis_s2.a), sn_s2);
			b_sn_s3  <= mul_trig(rpal_pkg::SUM_W'(axis_s2.b), sn_s2);
			c_sn_s3  <= mul_trig(rpal_pkg::SUM_W'(axis_s2.c), sn_s2);
		end
	end

	// ---------------- stage 4: matrix entries times (P - S) ----------------
	logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	always_comb begin
		m00 = MW'(aa_s3) + d0_s3;
		m01 = ab_oc_s3 - c_sn_s3;
		m02 = ac_oc_s3 + b_sn_s3;
		m10 = ab_oc_s3 + c_sn_s3;
		m11 = MW'(bb_s3) + d1_s3;
		m12 = bc_oc_s3 - a_sn_s3;
		m20 = ac_oc_s3 - b_sn_s3;
		m21 = bc_oc_s3 + a_sn_s3;
		m22 = MW'(cc_s3) + d2_s3;
	end

	function automatic logic signed [WW-1:0] mul_vec(
		input logic signed [MW-1:0] m, input logic signed [DW-1:0] v);
		logic signed [WW-1:0] mw, vw;
		mw = WW'(m);
		vw = WW'(v);
		return mw * vw;
	endfunction

	logic                 vld_s4;
	rpal_pkg::side_t      side_s4;
	logic signed [WW-1:0] p00_s4, p01_s4, p02_s4, p10_s4, p11_s4, p12_s4;
	logic signed [WW-1:0] p20_s4, p21_s4, p22_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			p00_s4  <= mul_vec(m00, side_s3.vx);
			p01_s4  <= mul_vec(m01, side_s3.vy);
			p02_s4  <= mul_vec(m02, side_s3.vz);
			p10_s4  <= mul_vec(m10, side_s3.vx);
			p11_s4  <= mul_vec(m11, side_s3.vy);
			p12_s4  <= mul_vec(m12, side_s3.vz);
			p20_s4  <= mul_vec(m20, side_s3.vx);
			p21_s4  <= mul_vec(m21, side_s3.vy);
			p22_s4  <= mul_vec(m22, side_s3.vz);
		end
	end

	// ---------------- stage 5: row sums, round to Q.F ----------------------
	logic signed [WW-1:0] acc0, acc1, acc2;
	assign acc0 = p00_s4 + p01_s4 + p02_s4 + ROUND_HALF;
	assign acc1 = p10_s4 + p11_s4 + p12_s4 + ROUND_HALF;
	assign acc2 = p20_s4 + p21_s4 + p22_s4 + ROUND_HALF;

	logic                               vld_s5;
	rpal_pkg::side_t                    side_s5;
	logic signed [rpal_pkg::ROW_W-1:0]  row0_s5, row1_s5, row2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			// floor shift by the matrix fraction: keep the upper bits
			row0_s5 <= acc0[WW-1:rpal_pkg::MAT_FRAC];
			row1_s5 <= acc1[WW-1:rpal_pkg::MAT_FRAC];
			row2_s5 <= acc2[WW-1:rpal_pkg::MAT_FRAC];
		end
	end

	// ---------------- stage 6: add start point, saturate, output register ---
	function automatic logic [CW-1:0] add_sat(
		input logic signed [rpal_pkg::ROW_W-1:0] r, input logic signed [CW-1:0] s);
		logic signed [rpal_pkg::RES_W-1:0] t;
		t = rpal_pkg::RES_W'(r) + rpal_pkg::RES_W'(s);
		if (t > rpal_pkg::RES_W'(32'sh7FFFFFFF))
			return 32'h7FFFFFFF;
		else if (t < rpal_pkg::RES_W'(32'sh80000000))
			return 32'h80000000;
		else
			return t[CW-1:0];
	endfunction

	logic [CW-1:0] rot_x_s6, rot_y_s6, rot_z_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s6 <= 1'b0;
		end else if (en) begin
			out_valid_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_x_s6 <= add_sat(row0_s5, side_s5.sx);
			rot_y_s6 <= add_sat(row1_s5, side_s5.sy);
			rot_z_s6 <= add_sat(row2_s5, side_s5.sz);
		end
	end

	assign m_axis_tvalid = out_valid_s6;
	assign m_axis_tdata  = {rot_z_s6, rot_y_s6, rot_x_s6};

endmodule
